[sv/tbf_pkg.sv]
// ----------------------------------------------------------------------------
// tbf_pkg
// Shared types and constants for the timestamp byte FIFO core.
// ----------------------------------------------------------------------------
package tbf_pkg;

  localparam int unsigned TBF_RING_DEPTH = 16;
  localparam int unsigned STAMP_W        = 64;
  localparam int unsigned COUNT_W        = 32;

  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    KIND_PUSH     = 2'd0,
    KIND_READ     = 2'd1,
    KIND_ROLLBACK = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_UNDERRUN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    STATE_IDLE,
    STATE_READ_DATA,
    STATE_RESULT
  } state_e;

endpackage

[sv/tbf_in_if.sv]
// ----------------------------------------------------------------------------
// tbf_in_if
// Command channel: valid/ready handshake with kind, timestamp and byte count.
// ----------------------------------------------------------------------------
interface tbf_in_if;
  logic            valid;
  logic            ready;
  tbf_pkg::kind_e  kind;
  tbf_pkg::stamp_t stamp_in;
  tbf_pkg::count_t byte_count;

  modport source (output valid, output kind, output stamp_in, output byte_count,
                  input ready);
  modport sink   (input valid, input kind, input stamp_in, input byte_count,
                  output ready);
endinterface

[sv/tbf_out_if.sv]
// ----------------------------------------------------------------------------
// tbf_out_if
// Result channel: valid/ready handshake with timestamp, status and shortfall.
// ----------------------------------------------------------------------------
interface tbf_out_if;
  logic             valid;
  logic             ready;
  tbf_pkg::stamp_t  stamp_out;
  tbf_pkg::status_e status;
  tbf_pkg::count_t  missing_bytes;

  modport source (output valid, output stamp_out, output status, output missing_bytes,
                  input ready);
  modport sink   (input valid, input stamp_out, input status, input missing_bytes,
                  output ready);
endinterface

[sv/tbf_ram.sv]
// ----------------------------------------------------------------------------
// tbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/timestamp_byte_fifo_core.sv]
// ----------------------------------------------------------------------------
// timestamp_byte_fifo_core
// Ring of timestamp records, each with a count of bytes not yet read.
// ----------------------------------------------------------------------------
// Usage: commands arrive on item_i (push, read, rollback, clear) and every
// command returns exactly one beat on result_o. A push stores a timestamp and
// byte count at the tail; a read consumes bytes from the oldest records and
// returns the timestamp of the first record it touches, or a status of empty
// or underrun with the number of bytes not covered.
// Records live in two RAMs (timestamp, remaining count) with registered read
// data; a read fetches, drains and writes back one record per cycle.
// Flow: an accepted command goes from IDLE to RESULT or, for a read that finds
// records, through READ_DATA once per record visited and then to RESULT.
// A new command is accepted once the previous one has moved from RESULT into
// the output register.
// Reset empties the ring and drops any pending result; RAM contents are not
// cleared since only written slots are ever read.
// When the receiver stalls, the result beat holds in the output register while
// the core still accepts and works on one further command.
// ----------------------------------------------------------------------------
module timestamp_byte_fifo_core #(
  parameter int unsigned RING_DEPTH = tbf_pkg::TBF_RING_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tbf_in_if.sink    item_i,
  tbf_out_if.source result_o
);
  import tbf_pkg::*;

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W = OCC_W + 1;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  oldest_q, oldest_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  count_t            need_q, need_d;
  logic              first_q, first_d;
  stamp_t            first_stamp_q, first_stamp_d;
  stamp_t            res_stamp_q, res_stamp_d;
  status_e           res_status_q, res_status_d;
  count_t            res_missing_q, res_missing_d;
  logic              out_valid_q, out_valid_d;
  stamp_t            out_stamp_q, out_stamp_d;
  status_e           out_status_q, out_status_d;
  count_t            out_missing_q, out_missing_d;

  logic              stamp_we, rem_we, ram_re;
  logic [IDX_W-1:0]  waddr, raddr;
  count_t            rem_wdata;
  stamp_t            stamp_rdata;
  count_t            rem_rdata;

  logic              accept;
  logic              ring_full;
  logic [SUM_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  tail_idx;
  logic [IDX_W-1:0]  oldest_next;
  count_t            rem_left, need_left;
  logic              drained;
  logic [OCC_W-1:0]  occ_after;
  logic [IDX_W-1:0]  oldest_after;
  stamp_t            cur_stamp;

  tbf_ram #(.WIDTH(STAMP_W), .DEPTH(RING_DEPTH)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (waddr),
    .wdata_i (item_i.stamp_in),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (stamp_rdata)
  );

  tbf_ram #(.WIDTH(COUNT_W), .DEPTH(RING_DEPTH)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (waddr),
    .wdata_i (rem_wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rem_rdata)
  );

  assign item_i.ready = (state_q == STATE_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign ring_full    = (occ_q == OCC_W'(RING_DEPTH));

  // Tail slot: oldest + occupancy, wrapped once (oldest below the depth, occupancy at most the depth).
  assign tail_sum = SUM_W'(oldest_q) + SUM_W'(occ_q);
  assign tail_idx = (tail_sum >= SUM_W'(RING_DEPTH)) ?
                    IDX_W'(tail_sum - SUM_W'(RING_DEPTH)) : IDX_W'(tail_sum);
  assign oldest_next = (oldest_q == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

  // Drain of the record just fetched.
  assign drained      = (need_q >= rem_rdata);
  assign rem_left     = drained ? '0 : rem_rdata - need_q;
  assign need_left    = drained ? need_q - rem_rdata : '0;
  assign occ_after    = drained ? occ_q - 1'b1 : occ_q;
  assign oldest_after = drained ? oldest_next : oldest_q;
  assign cur_stamp    = first_q ? stamp_rdata : first_stamp_q;

  always_comb begin
    state_d       = state_q;
    oldest_d      = oldest_q;
    occ_d         = occ_q;
    need_d        = need_q;
    first_d       = first_q;
    first_stamp_d = first_stamp_q;
    res_stamp_d   = res_stamp_q;
    res_status_d  = res_status_q;
    res_missing_d = res_missing_q;
    out_valid_d   = out_valid_q && !result_o.ready;
    out_stamp_d   = out_stamp_q;
    out_status_d  = out_status_q;
    out_missing_d = out_missing_q;
    stamp_we      = 1'b0;
    rem_we        = 1'b0;
    ram_re        = 1'b0;
    waddr         = tail_idx;
    raddr         = oldest_q;
    rem_wdata     = item_i.byte_count;

    case (state_q)
      STATE_IDLE: begin
        if (accept) begin
          res_stamp_d   = '0;
          res_status_d  = STATUS_OK;
          res_missing_d = '0;
          state_d       = STATE_RESULT;
          case (item_i.kind)
            KIND_PUSH: begin
              if (item_i.byte_count != '0) begin
                if (ring_full) begin
                  res_status_d = STATUS_FULL;
                end else begin
                  stamp_we = 1'b1;
                  rem_we   = 1'b1;
                  occ_d    = occ_q + 1'b1;
                end
              end
            end
            KIND_READ: begin
              if (item_i.byte_count != '0) begin
                if (occ_q == '0) begin
                  res_status_d  = STATUS_EMPTY;
                  res_missing_d = item_i.byte_count;
                end else begin
                  ram_re  = 1'b1;
                  need_d  = item_i.byte_count;
                  first_d = 1'b1;
                  state_d = STATE_READ_DATA;
                end
              end
            end
            KIND_ROLLBACK: begin
              if (occ_q != '0) begin
                occ_d = occ_q - 1'b1;
              end
            end
            KIND_CLEAR: begin
              oldest_d = '0;
              occ_d    = '0;
            end
            default: ;
          endcase
        end
      end

      STATE_READ_DATA: begin
        // Write back the drained count; advance past an emptied record.
        rem_we    = 1'b1;
        waddr     = oldest_q;
        rem_wdata = rem_left;
        first_d   = 1'b0;
        if (first_q) begin
          first_stamp_d = stamp_rdata;
        end
        oldest_d = oldest_after;
        occ_d    = occ_after;
        need_d   = need_left;
        if (need_left != '0 && occ_after != '0) begin
          ram_re = 1'b1;
          raddr  = oldest_after;
        end else begin
          res_missing_d = need_left;
          if (need_left != '0) begin
            res_stamp_d  = '0;
            res_status_d = STATUS_UNDERRUN;
          end else begin
            res_stamp_d  = cur_stamp;
            res_status_d = STATUS_OK;
          end
          state_d = STATE_RESULT;
        end
      end

      STATE_RESULT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d   = 1'b1;
          out_stamp_d   = res_stamp_q;
          out_status_d  = res_status_q;
          out_missing_d = res_missing_q;
          state_d       = STATE_IDLE;
        end
      end

      default: begin
        state_d = STATE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_IDLE;
      oldest_q    <= '0;
      occ_q       <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      occ_q       <= occ_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q        <= need_d;
    first_stamp_q <= first_stamp_d;
    res_stamp_q   <= res_stamp_d;
    res_status_q  <= res_status_d;
    res_missing_q <= res_missing_d;
    out_stamp_q   <= out_stamp_d;
    out_status_q  <= out_status_d;
    out_missing_q <= out_missing_d;
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.stamp_out     = out_stamp_q;
  assign result_o.status        = out_status_q;
  assign result_o.missing_bytes = out_missing_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(RING_DEPTH))
    else $error("occupancy exceeds ring depth");

  a_oldest_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q <= IDX_W'(RING_DEPTH - 1))
    else $error("oldest slot out of range");

  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == STATE_READ_DATA |-> occ_q != '0)
    else $error("draining a record from an empty ring");

  a_underrun_missing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == STATUS_UNDERRUN |-> out_missing_q != '0)
    else $error("underrun beat without missing bytes");

  a_push_updates_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stamp_we |=> occ_q == $past(occ_q) + 1'b1)
    else $error("push stored a record without counting it");

endmodule
